@@ sv/ssde_pkg.sv @@
// Shared types, constants and codes for the sampled standard deviation estimator.
// No dependencies; every other file imports this package.
package ssde_pkg;

	// default sizing
	localparam int DEF_STORE_DEPTH = 4096;
	localparam int DEF_SAMPLE_BITS = 16;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int STD_W    = 24;
	localparam int COUNT_W  = 13;
	localparam int PCT_W    = 7;
	localparam int MIN_W    = 13;
	localparam int CFG_W    = 13;
	localparam int DIV_W    = 64;
	localparam int ROOT_W   = 64;

	localparam logic [PCT_W-1:0] PCT_RESET = 7'd10;
	localparam logic [PCT_W-1:0] PCT_CAP   = 7'd100;
	localparam logic [MIN_W-1:0] MIN_RESET = 13'd100;

	// configuration register indexes
	typedef enum logic {
		REG_PERCENT = 1'b0,
		REG_MIN     = 1'b1
	} cfg_reg_t;

	// input transfer
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} smp_t;

	// result transfer
	typedef struct packed {
		logic [STD_W-1:0]   std_dev;
		logic [COUNT_W-1:0] used_count;
		logic               exact_mode;
		logic               overflow;
	} res_t;

	// which quotient is being formed: target by reciprocal multiply, the rest
	// by the shared divider
	typedef enum logic [1:0] {
		DIV_TARGET,
		DIV_STEP,
		DIV_MEAN,
		DIV_VAR
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_TGT,
		ST_DECIDE,
		ST_STEP,
		ST_STEP_W,
		ST_SUM_INIT,
		ST_SUM,
		ST_MEAN,
		ST_MEAN_W,
		ST_VAR_INIT,
		ST_VAR,
		ST_VDIV,
		ST_VDIV_W,
		ST_SQRT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic     load_en;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_cap;
		logic     decide;
		logic     pass_init;
		logic     rd;
		logic     var_pass;
		logic     sqrt_start;
		logic     res_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic set_done;
		logic exact_now;
		logic div_done;
		logic idx_end;
		logic pipe_busy;
		logic sqrt_done;
		logic res_busy;
	} sts_t;

endpackage

@@ sv/ssde_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ssde_pkg.
module ssde_div #(
	parameter int DVW = 13
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ssde_pkg::DIV_W-1:0] dividend,
	input  logic [DVW-1:0]            divisor,
	output logic [ssde_pkg::DIV_W-1:0] quotient,
	output logic                      rem_nz,
	output logic                      done
);
	import ssde_pkg::*;

	localparam int CNTW = $clog2(DIV_W);

	logic [DVW-1:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVW:0]     trial;
	logic [DVW:0]     diff;
	logic             ge;

	// trial subtract of the shifted partial remainder
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign rem_nz   = |rem_q;
	assign done     = done_q;

endmodule

@@ sv/ssde_sqrt.sv @@
// Digit-by-digit integer square root of a 64-bit value.
// Depends on ssde_pkg.
module ssde_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ssde_pkg::ROOT_W-1:0] radicand,
	output logic [ssde_pkg::ROOT_W-1:0] root,
	output logic                        done
);
	import ssde_pkg::*;

	logic [ROOT_W-1:0] v_q;
	logic [ROOT_W-1:0] res_q;
	logic [ROOT_W-1:0] bit_q;
	logic [ROOT_W-1:0] trial;
	logic              busy_q;
	logic              done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// one result digit per cycle, test bit moves down two places
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= ROOT_W'(1) << (ROOT_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q;
	assign done = done_q;

endmodule

@@ sv/ssde_dp.sv @@
// Datapath: sample store, configuration, pass pipeline, divider, root and result register.
// Depends on ssde_pkg, ssde_div and ssde_sqrt.
module ssde_dp #(
	parameter int STORE_DEPTH = ssde_pkg::DEF_STORE_DEPTH,
	parameter int SAMPLE_BITS = ssde_pkg::DEF_SAMPLE_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ssde_pkg::cmd_t            cmd,
	output ssde_pkg::sts_t            sts,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [ssde_pkg::CFG_W-1:0] cfg_data,
	input  logic                      smp_valid,
	output logic                      smp_stall,
	input  ssde_pkg::smp_t            smp,
	output logic                      res_valid,
	input  logic                      res_stall,
	output ssde_pkg::res_t            res
);
	import ssde_pkg::*;

	localparam int CW   = $clog2(STORE_DEPTH + 1);
	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int IW   = CW + 1;
	localparam int DVW  = (CW > PCT_W) ? CW : PCT_W;
	localparam int CMPW = (CW > MIN_W) ? CW : MIN_W;
	localparam int SUMW = SAMPLE_BITS + CW;
	localparam int SCW  = SUMW + 8;
	localparam int MW   = SAMPLE_BITS + 9;
	localparam int DW   = SAMPLE_BITS + 10;
	localparam int PW   = 2 * DW;
	localparam int NPW  = CW + PCT_W;
	// floor(np / 100) as (np * TGT_RCP) >> TSH, exact for np below 2^NPW
	localparam int TSH  = NPW + 7;
	localparam int RW   = NPW + 1;
	localparam longint unsigned TGT_RCP =
		((64'd1 << TSH) + 64'(PCT_CAP) - 64'd1) / 64'(PCT_CAP);

	// configuration
	logic [PCT_W-1:0] pct_q;
	logic [MIN_W-1:0] min_q;

	// load side
	logic [CW-1:0] loaded_q;
	logic          dropped_q;
	logic [CW-1:0] n_q;
	logic          ovf_q;
	logic          accept;
	logic          stored;
	logic [23:0]   raw_ext;
	logic [SAMPLE_BITS-1:0] wr_data;

	logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

	// estimate state
	logic [CW-1:0]  target_q;
	logic [CW-1:0]  step_q;
	logic           exact_q;
	logic [IW-1:0]  idx_q;
	logic [CW-1:0]  cnt_q;
	logic signed [SUMW-1:0] sum_q;
	logic signed [MW-1:0]   mean_q;
	logic [DIV_W-1:0]       vsum_q;

	// pass pipeline
	logic                          v_s1, v_s2, v_s3;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic signed [DW-1:0]          d_s2;
	logic [DIV_W-1:0]              sq_s3;
	logic signed [DW-1:0]          x_sc;
	logic [DW-1:0]                 ad;
	logic [PW-1:0]                 prod;
	logic [DIV_W:0]                vsum_add;

	// divider and root
	logic [DIV_W-1:0]       div_dividend;
	logic [DVW-1:0]         div_divisor;
	logic [DIV_W-1:0]       div_quo;
	logic                   div_rnz;
	logic                   div_done;
	logic [ROOT_W-1:0]      root;
	logic                   sqrt_done;
	logic [PCT_W-1:0]       pct_eff;
	logic [NPW-1:0]         np;
	logic [NPW+RW-1:0]      tgt_prod;
	logic signed [SCW-1:0]  scaled;
	logic [SCW-1:0]         scaled_abs;
	logic                   scaled_neg;
	logic signed [MW-1:0]   mq;
	logic                   exact_now;
	logic                   res_valid_q;
	res_t                   res_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= PCT_RESET;
			min_q <= MIN_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PERCENT: pct_q <= cfg_data[PCT_W-1:0];
				REG_MIN:     min_q <= cfg_data[MIN_W-1:0];
				default:     ;
			endcase
		end
	end

	// load: take low sample bits, store while room is left
	assign accept    = cmd.load_en && smp_valid;
	assign smp_stall = !cmd.load_en;
	assign stored    = loaded_q < CW'(STORE_DEPTH);
	assign raw_ext   = 24'($unsigned(smp.sample));
	assign wr_data   = raw_ext[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= '0;
			dropped_q <= 1'b0;
		end else if (accept) begin
			if (smp.last) begin
				loaded_q  <= '0;
				dropped_q <= 1'b0;
			end else if (stored) begin
				loaded_q <= loaded_q + 1'b1;
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && smp.last) begin
			n_q   <= stored ? loaded_q + 1'b1 : loaded_q;
			ovf_q <= dropped_q | !stored;
		end
	end

	// sample store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && stored) begin
			mem[loaded_q[AW-1:0]] <= wr_data;
		end
		if (cmd.rd) begin
			x_s1 <= $signed(mem[idx_q[AW-1:0]]);
		end
	end

	// target count by reciprocal multiply, divider operand selection
	assign pct_eff    = (pct_q > PCT_CAP) ? PCT_CAP : pct_q;
	assign np         = NPW'(n_q) * NPW'(pct_eff);
	assign tgt_prod   = (NPW+RW)'(np) * (NPW+RW)'(TGT_RCP);
	assign scaled     = SCW'(sum_q) <<< 8;
	assign scaled_neg = sum_q[SUMW-1];
	assign scaled_abs = scaled_neg ? SCW'(-scaled) : SCW'(scaled);

	always_comb begin
		case (cmd.div_sel)
			DIV_STEP: begin
				div_dividend = DIV_W'(n_q);
				div_divisor  = DVW'(target_q);
			end
			DIV_MEAN: begin
				div_dividend = DIV_W'(scaled_abs);
				div_divisor  = DVW'(cnt_q);
			end
			DIV_VAR: begin
				div_dividend = vsum_q;
				div_divisor  = DVW'(cnt_q);
			end
			default: begin
				div_dividend = '0;
				div_divisor  = DVW'(1);
			end
		endcase
	end

	ssde_div #(.DVW(DVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.rem_nz   (div_rnz),
		.done     (div_done)
	);

	// root starts on the variance divide's done, straight from the quotient
	ssde_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (div_quo),
		.root     (root),
		.done     (sqrt_done)
	);

	// exact fallback when the target is zero or under the minimum
	assign exact_now = (target_q == '0) || (CMPW'(target_q) < CMPW'(min_q));
	assign mq        = MW'(div_quo);

	// capture division results, mean rounds toward minus infinity
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			exact_q <= exact_now;
			if (exact_now) begin
				step_q <= CW'(1);
			end
		end
		if (cmd.div_cap) begin
			case (cmd.div_sel)
				DIV_TARGET: target_q <= tgt_prod[TSH+CW-1:TSH];
				DIV_STEP: begin
					if (div_quo == '0) begin
						step_q  <= CW'(1);
						exact_q <= 1'b1;
					end else begin
						step_q <= CW'(div_quo);
					end
				end
				DIV_MEAN: mean_q <= scaled_neg ? (-mq - MW'(div_rnz)) : mq;
				default:  ;
			endcase
		end
	end

	// pass address walk and first-pass sum
	always_ff @(posedge clk) begin
		if (cmd.pass_init) begin
			idx_q <= '0;
			if (!cmd.var_pass) begin
				cnt_q <= '0;
				sum_q <= '0;
			end
		end else begin
			if (cmd.rd) begin
				idx_q <= idx_q + IW'(step_q);
				if (!cmd.var_pass) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (v_s1 && !cmd.var_pass) begin
				sum_q <= sum_q + SUMW'(x_s1);
			end
		end
	end

	// second pass: deviation, square, saturating accumulate
	assign x_sc     = DW'(x_s1) <<< 8;
	assign ad       = d_s2[DW-1] ? DW'(-d_s2) : DW'(d_s2);
	assign prod     = PW'(ad) * PW'(ad);
	assign vsum_add = {1'b0, vsum_q} + {1'b0, sq_s3};

	always_ff @(posedge clk) begin
		d_s2  <= x_sc - DW'(mean_q);
		sq_s3 <= DIV_W'(prod);
		if (cmd.pass_init && cmd.var_pass) begin
			vsum_q <= '0;
		end else if (v_s3) begin
			vsum_q <= vsum_add[DIV_W] ? '1 : vsum_add[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd;
			v_s2 <= v_s1 && cmd.var_pass;
			v_s3 <= v_s2;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q.std_dev    <= (|root[ROOT_W-1:STD_W]) ? '1 : root[STD_W-1:0];
			res_q.used_count <= COUNT_W'(cnt_q);
			res_q.exact_mode <= exact_q;
			res_q.overflow   <= ovf_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// status
	assign sts.set_done  = accept && smp.last;
	assign sts.exact_now = exact_now;
	assign sts.div_done  = div_done;
	assign sts.idx_end   = idx_q >= IW'(n_q);
	assign sts.pipe_busy = v_s1 | v_s2 | v_s3;
	assign sts.sqrt_done = sqrt_done;
	assign sts.res_busy  = res_valid_q;

endmodule

@@ sv/ssde_ctrl.sv @@
// Controller: sequences load, target multiply and step divide, both passes, divides and root.
// Depends on ssde_pkg.
module ssde_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  ssde_pkg::sts_t sts,
	output ssde_pkg::cmd_t cmd
);
	import ssde_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD:     if (sts.set_done) state_nxt = ST_TGT;
			ST_TGT:      state_nxt = ST_DECIDE;
			ST_DECIDE:   state_nxt = sts.exact_now ? ST_SUM_INIT : ST_STEP;
			ST_STEP:     state_nxt = ST_STEP_W;
			ST_STEP_W:   if (sts.div_done) state_nxt = ST_SUM_INIT;
			ST_SUM_INIT: state_nxt = ST_SUM;
			ST_SUM:      if (sts.idx_end && !sts.pipe_busy) state_nxt = ST_MEAN;
			ST_MEAN:     state_nxt = ST_MEAN_W;
			ST_MEAN_W:   if (sts.div_done) state_nxt = ST_VAR_INIT;
			ST_VAR_INIT: state_nxt = ST_VAR;
			ST_VAR:      if (sts.idx_end && !sts.pipe_busy) state_nxt = ST_VDIV;
			ST_VDIV:     state_nxt = ST_VDIV_W;
			ST_VDIV_W:   if (sts.div_done) state_nxt = ST_SQRT;
			ST_SQRT:     if (sts.sqrt_done) state_nxt = ST_DONE;
			ST_DONE:     if (!sts.res_busy) state_nxt = ST_LOAD;
			default:     state_nxt = ST_LOAD;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.div_sel = DIV_TARGET;
		case (state_q)
			ST_LOAD:     cmd.load_en = 1'b1;
			ST_TGT:      cmd.div_cap = 1'b1;
			ST_DECIDE:   cmd.decide = 1'b1;
			ST_STEP: begin
				cmd.div_sel   = DIV_STEP;
				cmd.div_start = 1'b1;
			end
			ST_STEP_W: begin
				cmd.div_sel = DIV_STEP;
				cmd.div_cap = sts.div_done;
			end
			ST_SUM_INIT: cmd.pass_init = 1'b1;
			ST_SUM:      cmd.rd = !sts.idx_end;
			ST_MEAN: begin
				cmd.div_sel   = DIV_MEAN;
				cmd.div_start = 1'b1;
			end
			ST_MEAN_W: begin
				cmd.div_sel = DIV_MEAN;
				cmd.div_cap = sts.div_done;
			end
			ST_VAR_INIT: begin
				cmd.pass_init = 1'b1;
				cmd.var_pass  = 1'b1;
			end
			ST_VAR: begin
				cmd.var_pass = 1'b1;
				cmd.rd       = !sts.idx_end;
			end
			ST_VDIV: begin
				cmd.div_sel   = DIV_VAR;
				cmd.div_start = 1'b1;
			end
			ST_VDIV_W: begin
				cmd.div_sel    = DIV_VAR;
				cmd.div_cap    = sts.div_done;
				cmd.sqrt_start = sts.div_done;
			end
			ST_SQRT:     ;
			ST_DONE:     cmd.res_load = !sts.res_busy;
			default:     ;
		endcase
	end

endmodule

@@ sv/sampled_std_dev_estimator.sv @@
// Top level of the sampled standard deviation estimator: controller plus datapath.
// Depends on ssde_pkg, ssde_ctrl and ssde_dp.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   smp      | smp_valid / smp_stall  | sample (signed 16), last
//   res      | res_valid / res_stall  | std_dev Q16.8, used_count, exact, overflow
//   cfg      | cfg_we                 | cfg_index, cfg_data (write only)
//
// Samples load at one per cycle while the block is in its load state. After the
// last one, the set runs the target multiply, the step divide (sampled mode only),
// the sum pass, the mean divide, the variance pass, the variance divide and the root.
// The shared bit-serial divider and the store's single read port serialise this.
// Reset clears control only; the store needs no clearing pass.
// A waiting result does not block loading; a second set waits only for it.
module sampled_std_dev_estimator #(
	parameter int STORE_DEPTH = ssde_pkg::DEF_STORE_DEPTH,
	parameter int SAMPLE_BITS = ssde_pkg::DEF_SAMPLE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ssde_pkg::CFG_W-1:0] cfg_data,
	input  logic                       smp_valid,
	output logic                       smp_stall,
	input  ssde_pkg::smp_t             smp,
	output logic                       res_valid,
	input  logic                       res_stall,
	output ssde_pkg::res_t             res
);
	import ssde_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ssde_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	ssde_dp #(
		.STORE_DEPTH (STORE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

@@ sv/ssde_chk.sv @@
// Port-level checker for the estimator, attached by bind.
// Depends on ssde_pkg and sampled_std_dev_estimator.
module ssde_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           smp_valid,
	input logic           smp_stall,
	input ssde_pkg::smp_t smp,
	input logic           res_valid,
	input logic           res_stall,
	input ssde_pkg::res_t res
);
	import ssde_pkg::*;

	// a held result does not change
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// closing a set stops loading while the estimate runs
	a_set_close: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && !smp_stall && smp.last |=> smp_stall)
		else $error("input taken right after the last sample");

	// a new result only appears at the end of a compute phase
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(smp_stall))
		else $error("result appeared during loading");

	// every estimate uses at least one sample
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.used_count != '0)
		else $error("empty estimate");

endmodule

bind sampled_std_dev_estimator ssde_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.smp_valid (smp_valid),
	.smp_stall (smp_stall),
	.smp       (smp),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

@@ test/sampled_std_dev_estimator_tb.sv @@
// Testbench for the sampled standard deviation estimator: drives sample sets with random
// idling, predicts each result in its own model of the block and checks every result field.
// Depends on ssde_pkg and the sampled_std_dev_estimator RTL.
`timescale 1ns / 100ps

module sampled_std_dev_estimator_tb;
	import ssde_pkg::*;

	localparam int DEPTH = DEF_STORE_DEPTH;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              smp_valid;
	logic              smp_stall;
	smp_t              smp;
	logic              res_valid;
	logic              res_stall;
	res_t              res;

	sampled_std_dev_estimator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .smp_valid(smp_valid), .smp_stall(smp_stall), .smp(smp),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	// clock, 10 ns period
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	int unsigned      mdl_pct;
	int unsigned      mdl_min;
	int               mdl_store [DEPTH];
	int unsigned      mdl_loaded;
	bit               mdl_dropped;

	smp_t             pending_q [$];
	res_t             expected_q [$];
	int unsigned      send_idle_pct;
	int unsigned      recv_idle_pct;
	bit               hold_recv;
	int unsigned      mismatches;
	int unsigned      results_seen;
	int unsigned      sets_sent;
	int unsigned      exact_seen;
	int unsigned      sampled_seen;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// std dev over every step-th stored sample
	function automatic res_t estimate_set();
		res_t            r;
		int unsigned     n, pct, tgt, step, c, i;
		bit              exact;
		longint          sum, scaled, q, d;
		longint unsigned vsum, sq, ad, root;
		n = mdl_loaded;
		pct = (mdl_pct > 100) ? 100 : mdl_pct;
		tgt = (n * pct) / 100;
		exact = (tgt == 0) || (tgt < mdl_min);
		step = exact ? 1 : n / tgt;
		if (step == 0) begin
			step = 1;
			exact = 1'b1;
		end
		sum = 0;
		c = 0;
		for (i = 0; i < n; i += step) begin
			sum += mdl_store[i];
			c++;
		end
		scaled = sum * 256;
		q = scaled / longint'(c);
		if (scaled < 0 && q * longint'(c) != scaled)
			q -= 1;
		vsum = 0;
		for (i = 0; i < n; i += step) begin
			d = longint'(mdl_store[i]) * 256 - q;
			ad = (d < 0) ? longint'(-d) : d;
			sq = ad * ad;
			if (vsum > 64'hFFFF_FFFF_FFFF_FFFF - sq)
				vsum = 64'hFFFF_FFFF_FFFF_FFFF;
			else
				vsum += sq;
		end
		root = int_sqrt(vsum / longint'(c));
		if (root > 64'hFF_FFFF)
			root = 64'hFF_FFFF;
		r.std_dev = root[STD_W-1:0];
		r.used_count = c[COUNT_W-1:0];
		r.exact_mode = exact;
		r.overflow = mdl_dropped;
		return r;
	endfunction

	// advance the predictor by one accepted sample
	task automatic predict_sample(smp_t s);
		if (mdl_loaded < DEPTH) begin
			mdl_store[mdl_loaded] = int'(s.sample);
			mdl_loaded++;
		end else begin
			mdl_dropped = 1'b1;
		end
		if (s.last) begin
			expected_q.push_back(estimate_set());
			mdl_loaded = 0;
			mdl_dropped = 1'b0;
		end
	endtask

	// driver: offer the queue head, hold it while stalled
	always @(negedge clk) begin
		if (arst_n) begin
			if (smp_valid && !smp_stall) begin
				// handled at the posedge by the acceptance logic below
			end
		end
	end

	bit  drv_take;
	always @(posedge clk) begin
		drv_take <= smp_valid && !smp_stall && arst_n;
		if (smp_valid && !smp_stall && arst_n)
			predict_sample(smp);
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			smp_valid <= 1'b0;
		end else if (!smp_valid || drv_take) begin
			if (drv_take)
				void'(pending_q.pop_front());
			if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				smp <= pending_q[0];
				smp_valid <= 1'b1;
			end else begin
				smp_valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (hold_recv)
			res_stall <= 1'b1;
		else
			res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		res_t e;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", res);
			end else begin
				e = expected_q.pop_front();
				if (e.exact_mode)
					exact_seen++;
				else
					sampled_seen++;
				if (res !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: std %h/%h cnt %0d/%0d exact %b/%b ovf %b/%b",
							e.std_dev, res.std_dev, e.used_count, res.used_count,
							e.exact_mode, res.exact_mode, e.overflow, res.overflow);
				end
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PERCENT)
			mdl_pct = val & 8'h7F;
		else
			mdl_min = val & 16'h1FFF;
	endtask

	// wait until all queued samples are accepted and every result is back
	task automatic drain();
		int unsigned k;
		while (pending_q.size() > 0 || smp_valid || expected_q.size() > 0)
			@(posedge clk);
		for (k = 0; k < 50; k++)
			@(posedge clk);
	endtask

	task automatic make_set(int unsigned len, int unsigned mode, bit term);
		smp_t s;
		int unsigned i;
		for (i = 0; i < len; i++) begin
			case (mode)
				0: s.sample = 16'($urandom);
				1: s.sample = (i % 2) ? 16'sh7FFF : 16'sh8000;
				2: s.sample = 16'($urandom_range(20) - 10);
				default: s.sample = 16'sh8000;
			endcase
			s.last = term && (i == len - 1);
			pending_q.push_back(s);
		end
		if (term)
			sets_sent++;
	endtask

	task automatic random_sets(int unsigned items);
		int unsigned sent, len;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(300, 60) : $urandom_range(40, 1);
			make_set(len, $urandom_range(3), 1'b1);
			sent += len;
		end
	endtask

	initial begin
		int unsigned k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PERCENT;
		cfg_data = '0;
		smp_valid = 1'b0;
		smp = '0;
		res_stall = 1'b0;
		hold_recv = 1'b0;
		drv_take = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		mismatches = 0;
		results_seen = 0;
		sets_sent = 0;
		exact_seen = 0;
		sampled_seen = 0;
		mdl_pct = 10;
		mdl_min = 100;
		mdl_loaded = 0;
		mdl_dropped = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset config, single sample, extremes, constant set
		make_set(1, 3, 1'b1);
		make_set(2, 1, 1'b1);
		make_set(8, 0, 1'b1);
		make_set(5, 3, 1'b1);
		drain();

		// small min: sampled mode at 50 percent, percent over 100, and at zero (exact fallback)
		write_reg(REG_MIN, 0);
		write_reg(REG_PERCENT, 50);
		make_set(10, 0, 1'b1);
		drain();
		write_reg(REG_PERCENT, 127);
		make_set(7, 1, 1'b1);
		drain();
		write_reg(REG_PERCENT, 0);
		make_set(6, 0, 1'b1);
		drain();

		// phase 1: sender idles rarely, receiver often
		write_reg(REG_MIN, 2);
		write_reg(REG_PERCENT, 30);
		send_idle_pct = 9;
		recv_idle_pct = 50;
		random_sets(200);
		drain();

		// long receiver hold-off while the sender keeps offering
		hold_recv = 1'b1;
		random_sets(100);
		for (k = 0; k < 3000; k++)
			@(posedge clk);
		hold_recv = 1'b0;
		drain();

		// phase 2: roles swapped
		write_reg(REG_MIN, 0);
		write_reg(REG_PERCENT, 100);
		send_idle_pct = 50;
		recv_idle_pct = 9;
		random_sets(150);
		drain();

		// phase 3: no idling
		write_reg(REG_MIN, 5);
		write_reg(REG_PERCENT, 17);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_sets(160);
		drain();

		$display("covered %0d data sets, %0d exact and %0d sampled results checked",
			sets_sent, exact_seen, sampled_seen);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("sampled_std_dev_estimator_tb passed");
		else
			$display("sampled_std_dev_estimator_tb failed");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("sampled_std_dev_estimator_tb failed");
		$finish;
	end

endmodule

@@ files.f @@
sv/ssde_pkg.sv
sv/ssde_div.sv
sv/ssde_sqrt.sv
sv/ssde_dp.sv
sv/ssde_ctrl.sv
sv/sampled_std_dev_estimator.sv
sv/ssde_chk.sv
test/sampled_std_dev_estimator_tb.sv
